@@ sv/cpwc_pkg.sv @@
// ----------------------------------------------------------------------------
// cpwc_pkg: shared types and constants for the cluster prime classifier
// Field widths, status codes, register map and the constant prime tables
// from which the per-witness window masks are built.
// ----------------------------------------------------------------------------
package cpwc_pkg;

  localparam int VALUE_W     = 45;
  localparam int WITNESS_W   = 16;
  localparam int LIMIT_W     = 16;
  localparam int STATUS_W    = 2;
  localparam int WINDOW_BITS = 127;
  localparam int J_FIRST     = 9;
  localparam int MAX_J_DEF   = 255;
  localparam int J_TABLE     = 256;
  localparam int LIMIT_RESET = 3000;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_SMALL_LIMIT = 1'b0
  } reg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NOT_PRIME   = 2'd0,
    ST_BELOW_LIMIT = 2'd1,
    ST_CLUSTER     = 2'd2,
    ST_NON_CLUSTER = 2'd3
  } status_t;

  // Sieve of the small numbers, worked out at elaboration.
  function automatic logic [J_TABLE-1:0] prime_map_f();
    logic [J_TABLE-1:0] m;
    m    = '1;
    m[0] = 1'b0;
    m[1] = 1'b0;
    for (int i = 2; i * i < J_TABLE; i++) begin
      if (m[i]) begin
        for (int k = i * i; k < J_TABLE; k += i) begin
          m[k] = 1'b0;
        end
      end
    end
    return m;
  endfunction

  localparam logic [J_TABLE-1:0] PRIME_MAP = prime_map_f();

  // History positions that must all be non-prime for witness j:
  // bit (j-k)/2-1 for every odd prime k < j.
  function automatic logic [WINDOW_BITS-1:0] j_mask(int j);
    logic [WINDOW_BITS-1:0] m;
    m = '0;
    for (int k = 3; k < j; k += 2) begin
      if (PRIME_MAP[k]) begin
        m[(j - k) / 2 - 1] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

@@ sv/cpwc_if.sv @@
// ----------------------------------------------------------------------------
// cpwc_item_if / cpwc_result_if: valid/ready channels of the classifier
// Input transactions carry an odd number with its primality and mark;
// output transactions carry the classification.
// ----------------------------------------------------------------------------
interface cpwc_item_if import cpwc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VALUE_W-1:0]   odd_value;
  logic                 is_prime;
  logic [WITNESS_W-1:0] mark_witness;

  modport source (output valid, odd_value, is_prime, mark_witness, input ready);
  modport sink   (input valid, odd_value, is_prime, mark_witness, output ready);
endinterface

interface cpwc_result_if import cpwc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VALUE_W-1:0]   prime_value;
  logic [STATUS_W-1:0]  status;
  logic [WITNESS_W-1:0] witness_j;

  modport source (output valid, prime_value, status, witness_j, input ready);
  modport sink   (input valid, prime_value, status, witness_j, output ready);
endinterface

@@ sv/cluster_prime_window_classifier.sv @@
// ----------------------------------------------------------------------------
// cluster_prime_window_classifier: cluster prime window classifier
// Result path: input transaction into a queue entry, then the back's output
//   register, which drives the result. Throughput: one transaction per cycle
//   while the queue has room; when an output stall clears with the queue full,
//   input ready stays low until the cycle after the pop that frees an entry.
// Reset (rst, synchronous): history cleared to non-prime, queue and output
//   emptied, small_limit back to 3000.
// ----------------------------------------------------------------------------
module cluster_prime_window_classifier import cpwc_pkg::*; #(
  parameter int MAX_J = MAX_J_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration (APB style, pready tied high)
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // data channels
  cpwc_item_if.sink             item,
  cpwc_result_if.source         result
);

  // One match bit per odd candidate j in 9..MAX_J travels with each record.
  localparam int NUM_J = (MAX_J - J_FIRST) / 2 + 1;
  localparam int REC_W = VALUE_W + 2 + WITNESS_W + NUM_J;

  logic [LIMIT_W-1:0] small_limit;
  reg_idx_t           reg_sel;
  logic               cfg_write;

  logic               push_valid;
  logic               push_ready;
  logic [REC_W-1:0]   push_data;
  logic               pop_valid;
  logic               pop_ready;
  logic [REC_W-1:0]   pop_data;

  // ---- configuration register ----
  // Byte offset bits are ignored; paddr[2] selects the register.
  assign pready    = 1'b1;
  assign reg_sel   = reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      small_limit <= LIMIT_W'(LIMIT_RESET);
    end else if (cfg_write && reg_sel == REG_SMALL_LIMIT) begin
      small_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == REG_SMALL_LIMIT) begin
      prdata = APB_DATA_W'(small_limit);
    end
  end

  // ---- front: history shift and mask tests ----
  cpwc_front #(
    .MAX_J (MAX_J),
    .NUM_J (NUM_J),
    .REC_W (REC_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .small_limit (small_limit),
    .item        (item),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  // ---- queue: decouples front from output stalls ----
  cpwc_queue #(
    .WIDTH (REC_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // ---- back: witness pick, status, output register ----
  cpwc_back #(
    .MAX_J (MAX_J),
    .NUM_J (NUM_J),
    .REC_W (REC_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

endmodule

@@ sv/cpwc_front.sv @@
// ----------------------------------------------------------------------------
// cpwc_front: history register and parallel window mask tests
// Accepts a transaction, tests every candidate witness against the prime
// history in one pass and pushes the packed record into the queue.
// ----------------------------------------------------------------------------
module cpwc_front import cpwc_pkg::*; #(
  parameter int MAX_J = MAX_J_DEF,
  parameter int NUM_J = (MAX_J - J_FIRST) / 2 + 1,
  parameter int REC_W = VALUE_W + 2 + WITNESS_W + NUM_J
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [LIMIT_W-1:0] small_limit,
  cpwc_item_if.sink          item,
  output logic               push_valid,
  input  logic               push_ready,
  output logic [REC_W-1:0]   push_data
);

  logic [WINDOW_BITS-1:0] history;
  logic [NUM_J-1:0]       match;
  logic                   below;
  logic                   accept;

  // one candidate per odd j; prime j never qualifies
  for (genvar g = 0; g < NUM_J; g++) begin : g_cand
    localparam int J = J_FIRST + 2 * g;
    localparam logic [WINDOW_BITS-1:0] MASK = j_mask(J);
    assign match[g] = PRIME_MAP[J] ? 1'b0 : ~|(history & MASK);
  end

  assign below      = item.odd_value < VALUE_W'(small_limit);
  assign item.ready = push_ready;
  assign accept     = item.valid && push_ready;
  assign push_valid = item.valid;
  assign push_data  = {item.odd_value, item.is_prime, below, item.mark_witness, match};

  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
    end else if (accept) begin
      history <= {history[WINDOW_BITS-2:0], item.is_prime};
    end
  end

endmodule

@@ sv/cpwc_queue.sv @@
// ----------------------------------------------------------------------------
// cpwc_queue: two-entry queue between front and back
// Lets the front keep accepting while the back waits on the output.
// ----------------------------------------------------------------------------
module cpwc_queue import cpwc_pkg::*; #(
  parameter int WIDTH = VALUE_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign pop_data   = entry[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sv/cpwc_back.sv @@
// ----------------------------------------------------------------------------
// cpwc_back: witness selection and output register
// Picks the smallest qualifying witness, or a nonzero mark, resolves the
// status and holds the result until the output transaction completes.
// ----------------------------------------------------------------------------
module cpwc_back import cpwc_pkg::*; #(
  parameter int MAX_J = MAX_J_DEF,
  parameter int NUM_J = (MAX_J - J_FIRST) / 2 + 1,
  parameter int REC_W = VALUE_W + 2 + WITNESS_W + NUM_J
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  logic [REC_W-1:0] pop_data,
  cpwc_result_if.source    result
);

  localparam int IDX_W = $clog2(NUM_J + 1);

  logic [VALUE_W-1:0]   r_value;
  logic                 r_prime;
  logic                 r_below;
  logic [WITNESS_W-1:0] r_mark;
  logic [NUM_J-1:0]     r_match;
  logic [IDX_W-1:0]     first_idx;
  logic                 hit;
  status_t              status_next;
  logic [WITNESS_W-1:0] witness_next;
  logic                 out_valid;
  logic [VALUE_W-1:0]   out_value;
  status_t              out_status;
  logic [WITNESS_W-1:0] out_witness;

  assign {r_value, r_prime, r_below, r_mark, r_match} = pop_data;

  // lowest set bit = smallest j
  always_comb begin
    first_idx = '0;
    for (int i = NUM_J - 1; i >= 0; i--) begin
      if (r_match[i]) first_idx = IDX_W'(i);
    end
  end
  assign hit = |r_match;

  always_comb begin
    witness_next = '0;
    if (!r_prime) begin
      status_next = ST_NOT_PRIME;
    end else if (r_below) begin
      status_next = ST_BELOW_LIMIT;
    end else if (r_mark != '0) begin
      status_next  = ST_NON_CLUSTER;
      witness_next = r_mark;
    end else if (hit) begin
      status_next  = ST_NON_CLUSTER;
      witness_next = WITNESS_W'(J_FIRST) + (WITNESS_W'(first_idx) << 1);
    end else begin
      status_next = ST_CLUSTER;
    end
  end

  assign pop_ready = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_ready) begin
      out_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      out_value   <= r_value;
      out_status  <= status_next;
      out_witness <= witness_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.prime_value = out_value;
  assign result.status      = out_status;
  assign result.witness_j   = out_witness;

endmodule

@@ dv/cluster_prime_window_classifier_tb.sv @@
// ----------------------------------------------------------------------------
// cluster_prime_window_classifier_tb: self-checking testbench
// Drives odd-number transactions with sieve-true or random primality and
// external marks. Every result is checked against a local classifier that
// keeps its own 127-bit prime history and small_limit copy. Sender bursts,
// receiver stalls and a long output hold-off exercise the flow control.
// ----------------------------------------------------------------------------
module cluster_prime_window_classifier_tb;
  import cpwc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 4;   // a little over the result latency
  localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = {REG_SMALL_LIMIT, 2'b00};

  // how a stream picks primality for its odd numbers
  typedef enum {
    FEED_SIEVE,   // true primality of consecutive small odd numbers
    FEED_RANDOM,  // consecutive values, primality drawn at a given density
    FEED_NOISE    // every field random, values not consecutive or even odd
  } feed_t;

  typedef struct {
    logic [VALUE_W-1:0]   value;
    status_t              status;
    logic [WITNESS_W-1:0] witness;
  } classification_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  cpwc_item_if   item_ch();
  cpwc_result_if result_ch();

  cluster_prime_window_classifier dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (item_ch),
    .result  (result_ch)
  );

  // Local copy of the classifier state.
  logic [WINDOW_BITS-1:0] prime_window;
  logic [LIMIT_W-1:0]     limit_shadow;
  logic [WINDOW_BITS-1:0] witness_mask [0:MAX_J_DEF];
  bit                     odd_composite [0:MAX_J_DEF];

  classification_t pending_results [$];
  int              error_count;
  int              cycle_count;

  // Sender pacing: bursts of random length, gaps up to gap_max (0 = none).
  int gap_max;
  int burst_left;

  // Receiver: hold requests from the tests, stall pattern of its own.
  int hold_reqs;
  int hold_taken;
  int hold_left;
  int ready_pct;
  int pattern_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, counted over the whole run including reset.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Trial division; fine for the window table and for stream values < 2^23.
  function automatic bit is_prime_num(longint unsigned n);
    longint unsigned d;
    if (n < 2) return 1'b0;
    if (n % 2 == 0) return n == 2;
    for (d = 3; d * d <= n; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Expected classification of one transaction against the current history.
  // A prime at or above the limit takes a nonzero mark as its witness;
  // otherwise the first odd composite j whose mask finds no prime wins.
  function automatic classification_t classify(logic [VALUE_W-1:0] v, logic prime,
                                               logic [WITNESS_W-1:0] mark,
                                               logic [WINDOW_BITS-1:0] hist,
                                               logic [LIMIT_W-1:0] lim);
    classification_t c;
    int j;
    c.value   = v;
    c.status  = ST_NOT_PRIME;
    c.witness = '0;
    if (!prime) begin
      c.status = ST_NOT_PRIME;
    end else if (v < lim) begin
      c.status = ST_BELOW_LIMIT;
    end else if (mark != '0) begin
      c.status  = ST_NON_CLUSTER;
      c.witness = mark;
    end else begin
      c.status = ST_CLUSTER;
      for (j = J_FIRST; j <= MAX_J_DEF && c.status == ST_CLUSTER; j += 2) begin
        if (odd_composite[j] && (hist & witness_mask[j]) == '0) begin
          c.status  = ST_NON_CLUSTER;
          c.witness = WITNESS_W'(j);
        end
      end
    end
    return c;
  endfunction

  // Monitor: input side first so a same-cycle result would still find its
  // expectation; both handshakes sampled at the same rising edge.
  always @(posedge clk) begin : monitor
    classification_t want;
    if (!rst) begin
      if (item_ch.valid && item_ch.ready) begin
        pending_results.push_back(classify(item_ch.odd_value, item_ch.is_prime,
                                           item_ch.mark_witness, prime_window,
                                           limit_shadow));
        prime_window = {prime_window[WINDOW_BITS-2:0], item_ch.is_prime};
      end
      if (result_ch.valid && result_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with none pending: prime_value %0d",
                 result_ch.prime_value);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (result_ch.prime_value !== want.value) begin
            $error("prime_value: expected %0d, got %0d", want.value,
                   result_ch.prime_value);
            error_count++;
          end
          if (result_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d (prime_value %0d)", want.status,
                   result_ch.status, want.value);
            error_count++;
          end
          if (result_ch.witness_j !== want.witness) begin
            $error("witness_j: expected %0d, got %0d (prime_value %0d)", want.witness,
                   result_ch.witness_j, want.value);
            error_count++;
          end
        end
      end
    end
  end

  // Receiver: random ready at a rate redrawn when its pattern count runs out,
  // including full-rate stretches; a hold request forces a long stall.
  always @(negedge clk) begin
    if (hold_taken != hold_reqs) begin
      hold_taken = hold_reqs;
      hold_left  = HOLD_CYCLES;
    end
    if (pattern_left == 0) begin
      case ($urandom_range(0, 4))
        0, 1:    ready_pct = 100;
        2:       ready_pct = 80;
        3:       ready_pct = 50;
        default: ready_pct = 20;
      endcase
      pattern_left = $urandom_range(16, 96);
    end else begin
      pattern_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  // One transaction. Called at a falling edge, returns at a falling edge;
  // valid is left high unless a gap starts, so back-to-back items never
  // drop and re-raise valid in the same step.
  task automatic send_item(logic [VALUE_W-1:0] v, logic prime, logic [WITNESS_W-1:0] mark);
    item_ch.valid        <= 1'b1;
    item_ch.odd_value    <= v;
    item_ch.is_prime     <= prime;
    item_ch.mark_witness <= mark;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
    if (gap_max > 0) begin
      if (burst_left == 0) begin
        item_ch.valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Sender pause until every expected result is back, then a short settle.
  task automatic wait_drain();
    item_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic readback_limit();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= LIMIT_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DATA_W'(limit_shadow)) begin
      $error("small_limit readback: expected %0d, got %0d", limit_shadow, prdata);
      error_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Only called with the block idle.
  task automatic program_limit(logic [LIMIT_W-1:0] lim);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= APB_DATA_W'(lim);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    limit_shadow = lim;
    @(negedge clk);
    readback_limit();
  endtask

  task automatic run_stream(feed_t feed, logic [VALUE_W-1:0] start, int count,
                            int prime_pct, int mark_pct);
    logic [VALUE_W-1:0]   v;
    logic                 prime;
    logic [WITNESS_W-1:0] mark;
    v = start;
    for (int i = 0; i < count; i++) begin
      case (feed)
        FEED_SIEVE:  prime = is_prime_num(v);
        FEED_RANDOM: prime = ($urandom_range(1, 100) <= prime_pct);
        default: begin
          v     = VALUE_W'({$urandom, $urandom});
          prime = $urandom_range(0, 1);
        end
      endcase
      mark = '0;
      if ($urandom_range(1, 100) <= mark_pct) begin
        case ($urandom_range(0, 3))
          0:       mark = '1;
          1:       mark = WITNESS_W'($urandom_range(1, 255));
          default: mark = WITNESS_W'($urandom_range(1, 65535));
        endcase
      end
      send_item(v, prime, mark);
      v += 2;
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // small_limit must come out of reset at its default
  task automatic test_reset_value();
    readback_limit();
  endtask

  // From a fresh (all non-prime) history with no limit: 3 finds witness 9
  // at once, then the window fills with the true small primes.
  task automatic test_fresh_small_primes();
    program_limit('0);
    gap_max = 0;
    run_stream(FEED_SIEVE, VALUE_W'(1), 15, 0, 0);
  endtask

  // Field extremes at the default limit: marks ignored on non-primes and
  // below the limit, the limit boundary itself, the widest value with the
  // widest mark, and values that skip around.
  task automatic test_field_extremes();
    wait_drain();
    program_limit(LIMIT_W'(LIMIT_RESET));
    gap_max = 3;
    send_item(VALUE_W'(1), 1'b0, '0);
    send_item('1, 1'b0, '1);
    send_item('1, 1'b1, '1);
    send_item(VALUE_W'(LIMIT_RESET - 1), 1'b1, WITNESS_W'(1));
    send_item(VALUE_W'(LIMIT_RESET), 1'b1, '0);
    send_item(VALUE_W'(LIMIT_RESET + 1), 1'b1, WITNESS_W'(1));
    send_item(VALUE_W'(2), 1'b1, '0);
  endtask

  // Several limit settings; each runs sieve-true streams around the limit (if
  // over 300) and further up, dense random primality at large values, and noise.
  task automatic test_random_streams();
    logic [LIMIT_W-1:0] lim;
    logic [VALUE_W-1:0] base;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       lim = '1;
        1:       lim = '0;
        2:       lim = LIMIT_W'($urandom_range(1, 65534));
        default: lim = LIMIT_W'(LIMIT_RESET);
      endcase
      wait_drain();
      program_limit(lim);
      gap_max = 3 * $urandom_range(0, 3);
      if (lim > 300) base = VALUE_W'(lim - $urandom_range(0, 240)) | VALUE_W'(1);
      else base = VALUE_W'($urandom_range(1, 70000)) | VALUE_W'(1);
      run_stream(FEED_SIEVE, base, 120, 0, 10);
      run_stream(FEED_SIEVE, VALUE_W'($urandom_range(1, 1 << 22)) | VALUE_W'(1), 40, 0, 10);
      gap_max = 3 * $urandom_range(0, 3);
      run_stream(FEED_RANDOM, VALUE_W'({$urandom, $urandom}) | VALUE_W'(1), 60,
                 $urandom_range(40, 95), 10);
      run_stream(FEED_NOISE, '0, 10, 0, 30);
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the block fills and stalls its input; then the sender waits it out.
  task automatic test_backpressure();
    gap_max = 0;
    hold_reqs++;
    run_stream(FEED_SIEVE, VALUE_W'($urandom_range(3000, 60000)) | VALUE_W'(1), 80, 0, 5);
    wait_drain();
  endtask

  initial begin
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    item_ch.valid        = 1'b0;
    item_ch.odd_value    = '0;
    item_ch.is_prime     = 1'b0;
    item_ch.mark_witness = '0;
    result_ch.ready      = 1'b0;
    prime_window         = '0;
    limit_shadow         = LIMIT_W'(LIMIT_RESET);
    error_count          = 0;
    cycle_count          = 0;
    gap_max              = 0;
    burst_left           = 0;
    hold_reqs            = 0;
    hold_taken           = 0;
    hold_left            = 0;
    ready_pct            = 100;
    pattern_left         = 0;

    // Window mask per witness j: history bit (j-k)/2-1 for each odd prime k < j.
    for (int j = 0; j <= MAX_J_DEF; j++) begin
      witness_mask[j]  = '0;
      odd_composite[j] = (j % 2 == 1) && (j >= J_FIRST) && !is_prime_num(j);
      for (int k = 3; k < j; k += 2) begin
        if (is_prime_num(k)) witness_mask[j][(j - k) / 2 - 1] = 1'b1;
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_value();
    test_fresh_small_primes();
    test_field_extremes();
    test_random_streams();
    test_backpressure();

    wait_drain();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
